/* design/aeks_pkg.sv */
package aeks_pkg;

	localparam int KEY_W      = 6;
	localparam int KEY_EXT_W  = 9;
	localparam int SAMPLE_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int NB_W       = 8;
	localparam int DENOM_W    = 8;
	// Divisor width of the shared divider: holds 7 * 255.
	localparam int DEN_W      = 11;

	localparam logic [DEN_W-1:0] RAMP_FACTOR = 11'd7;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ENABLE = 3'd0;
	localparam cfg_idx_t REG_ARMED  = 3'd1;
	localparam cfg_idx_t REG_NOISE  = 3'd2;
	localparam cfg_idx_t REG_SLOW   = 3'd3;
	localparam cfg_idx_t REG_FAST   = 3'd4;

	localparam logic              RST_ENABLE = 1'b1;
	localparam logic              RST_ARMED  = 1'b0;
	localparam logic [NB_W-1:0]   RST_NOISE  = 8'd2;
	localparam logic [DENOM_W-1:0] RST_SLOW  = 8'd32;
	localparam logic [DENOM_W-1:0] RST_FAST  = 8'd2;

	typedef enum logic [1:0] {
		PATH_PASS   = 2'd0,
		PATH_BYPASS = 2'd1,
		PATH_SMOOTH = 2'd2
	} path_t;

endpackage

/* design/aeks_in_if.sv */
interface aeks_in_if;
	logic                           valid;
	logic                           ready;
	logic [aeks_pkg::KEY_W-1:0]     key_index;
	logic [aeks_pkg::SAMPLE_W-1:0]  raw_sample;

	modport source (output valid, key_index, raw_sample, input ready);
	modport sink   (input valid, key_index, raw_sample, output ready);
endinterface

/* design/aeks_out_if.sv */
interface aeks_out_if;
	logic                           valid;
	logic                           ready;
	logic [aeks_pkg::SAMPLE_W-1:0]  filtered_sample;
	aeks_pkg::path_t                path_taken;

	modport source (output valid, filtered_sample, path_taken, input ready);
	modport sink   (input valid, filtered_sample, path_taken, output ready);
endinterface

/* design/aeks_cfg_if.sv */
interface aeks_cfg_if;
	logic                            valid;
	logic                            ready;
	aeks_pkg::cfg_idx_t              index;
	logic [aeks_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface

/* design/aeks_div.sv */
module aeks_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	// Restoring division: the dividend shifts out of quo_q from the top while
	// quotient bits shift in at the bottom, one bit per cycle.
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* design/aeks_store.sv */
module aeks_store #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// An entry that has not been written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

/* design/adaptive_ema_key_smoother.sv */
// Per-key adaptive exponential smoother.
// The samples channel carries a key index and a raw sample; the results channel
// returns one transaction per sample: the integer part of the updated filtered
// value and the path taken (passthrough, large-error bypass or smoothed).
// The cfg channel writes the five control registers; it is always ready and
// must only be used while the block is idle.
// One sample is processed at a time. Passthrough and out-of-range keys go
// straight to the final step that loads the result register; a bypass first
// compares against the stored value, a smoothed sample with minimum gain then
// multiplies and applies the gain, and a smoothed sample on the gain ramp
// first computes the ramp on the bit-serial divider. The first smoothed sample
// after a denominator write also recomputes both gains on the same divider.
// The result sits in an output register, so the next sample is accepted while
// a result waits; a stalled receiver holds the block in its final step once a
// second result is ready. Reset clears the per-key store to zero and loads
// the register defaults.
module adaptive_ema_key_smoother #(
	parameter int KEY_COUNT    = 64,
	parameter int BYPASS_LIMIT = 64,
	parameter int FRAC_BITS    = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	aeks_cfg_if.sink    cfg,
	aeks_in_if.sink     samples,
	aeks_out_if.source  results
);

	localparam int OUT_W = aeks_pkg::SAMPLE_W;
	localparam int SW    = (SAMPLE_BITS < OUT_W) ? SAMPLE_BITS : OUT_W;
	localparam int MW    = SW + FRAC_BITS;
	localparam int AW    = FRAC_BITS + 1;
	localparam int KW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int KX    = aeks_pkg::KEY_EXT_W;
	localparam int DIV_W = SW + FRAC_BITS + 2;
	localparam int DEN_W = aeks_pkg::DEN_W;
	localparam int NB_W  = aeks_pkg::NB_W;
	localparam int DNW   = aeks_pkg::DENOM_W;
	localparam int RPW   = SW + AW;
	localparam int PW    = AW + MW;
	localparam int CRW   = PW + 1;

	localparam logic [AW-1:0]    Q_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [CRW-1:0]   FRAC_MASK = CRW'({FRAC_BITS{1'b1}});
	localparam logic [KX-1:0]    KEY_LIMIT = KX'(KEY_COUNT);
	localparam logic [MW+10:0]   BYP_Q     = (MW + 11)'(BYPASS_LIMIT) << FRAC_BITS;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_MAG   = 11'b000_0000_0010,
		S_GMIN  = 11'b000_0000_0100,
		S_GMAX  = 11'b000_0000_1000,
		S_SEL   = 11'b000_0001_0000,
		S_RMUL  = 11'b000_0010_0000,
		S_RDIV  = 11'b000_0100_0000,
		S_AMUL  = 11'b000_1000_0000,
		S_APPLY = 11'b001_0000_0000,
		S_DONE  = 11'b010_0000_0000,
		S_HOLD  = 11'b100_0000_0000
	} state_t;

	// Configuration registers.
	logic             enable_q;
	logic             armed_q;
	logic [NB_W-1:0]  nb_q;
	logic [DNW-1:0]   slow_q;
	logic [DNW-1:0]   fast_q;
	logic             stale_q;

	state_t           state_q;
	state_t           state_d;
	logic             div_go_q;
	logic             div_go_d;
	logic             out_valid_q;

	// Item payload.
	logic [KW-1:0]     addr_q;
	logic [SW-1:0]     sample_q;
	logic [MW-1:0]     prev_q;
	logic [MW-1:0]     mag_q;
	logic              neg_q;
	logic [SW-1:0]     err_q;
	logic [AW-1:0]     amin_q;
	logic [AW-1:0]     amax_q;
	logic [AW-1:0]     alpha_q;
	logic [RPW-1:0]    rprod_q;
	logic [PW-1:0]     prod_q;
	logic [SW-1:0]     res_sample_q;
	aeks_pkg::path_t   res_path_q;
	logic [DIV_W-1:0]  div_num_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [OUT_W-1:0]  out_sample_q;
	aeks_pkg::path_t   out_path_q;

	logic              accept;
	logic              cfg_acc;
	logic              smooth_on;
	logic [KX-1:0]     key_ext;
	logic              key_ok;
	logic [SW-1:0]     raw_in;
	logic              out_free;
	logic              store_clear;
	logic              gain_loaded;

	logic              st_rd_en;
	logic [MW-1:0]     st_rd_data;
	logic              st_wr_en;
	logic [KW-1:0]     st_wr_addr;
	logic [MW-1:0]     st_wr_data;

	logic [MW-1:0]     sample_fx;
	logic              neg_c;
	logic [MW-1:0]     mag_c;
	logic              bypass_c;
	logic [DNW-1:0]    d_hi;
	logic [DNW-1:0]    d_lo;
	logic [DNW-1:0]    d_slow;
	logic [DNW-1:0]    d_fast;
	logic [AW-1:0]     adiff;
	logic [SW-1:0]     ediff;
	logic              in_band;
	logic [DEN_W-1:0]  span_c;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;
	logic [AW-1:0]     ramp_alpha;
	logic [CRW-1:0]    corr_dn;
	logic [PW-1:0]     corr_up;
	logic [MW-1:0]     result_c;

	assign accept    = samples.valid && samples.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign smooth_on = enable_q && armed_q;
	assign key_ext   = KX'(samples.key_index);
	assign key_ok    = key_ext < KEY_LIMIT;
	assign raw_in    = samples.raw_sample[SW-1:0];
	assign out_free  = !out_valid_q || results.ready;

	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;

	assign results.valid           = out_valid_q;
	assign results.filtered_sample = out_sample_q;
	assign results.path_taken      = out_path_q;

	// A change of the enable value wipes every key's history.
	assign store_clear = cfg_acc && (cfg.index == aeks_pkg::REG_ENABLE)
	                     && (cfg.wdata[0] != enable_q);
	assign gain_loaded = (state_q == S_GMAX) && div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= aeks_pkg::RST_ENABLE;
			armed_q  <= aeks_pkg::RST_ARMED;
			nb_q     <= aeks_pkg::RST_NOISE;
			slow_q   <= aeks_pkg::RST_SLOW;
			fast_q   <= aeks_pkg::RST_FAST;
			stale_q  <= 1'b1;
		end else begin
			if (gain_loaded) begin
				stale_q <= 1'b0;
			end
			if (cfg_acc) begin
				unique case (cfg.index)
					aeks_pkg::REG_ENABLE: begin
						if (store_clear) begin
							enable_q <= cfg.wdata[0];
							armed_q  <= 1'b0;
						end
					end
					aeks_pkg::REG_ARMED: armed_q <= cfg.wdata[0];
					aeks_pkg::REG_NOISE: nb_q <= cfg.wdata;
					aeks_pkg::REG_SLOW: begin
						slow_q  <= cfg.wdata;
						stale_q <= 1'b1;
					end
					aeks_pkg::REG_FAST: begin
						fast_q  <= cfg.wdata;
						stale_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	aeks_store #(
		.DEPTH  (KEY_COUNT),
		.ADDR_W (KW),
		.DATA_W (MW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (store_clear),
		.rd_en   (st_rd_en),
		.rd_addr (key_ext[KW-1:0]),
		.rd_data (st_rd_data),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data)
	);

	aeks_div #(
		.NUM_W (DIV_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Error magnitude against the stored value.
	assign sample_fx = {sample_q, {FRAC_BITS{1'b0}}};
	assign neg_c     = sample_fx < st_rd_data;
	assign mag_c     = neg_c ? (st_rd_data - sample_fx) : (sample_fx - st_rd_data);
	assign bypass_c  = {11'b0, mag_c} >= BYP_Q;

	// The larger denominator gives the minimum gain; zero counts as one.
	assign d_hi   = (slow_q >= fast_q) ? slow_q : fast_q;
	assign d_lo   = (slow_q >= fast_q) ? fast_q : slow_q;
	assign d_slow = (d_hi == '0) ? DNW'(1) : d_hi;
	assign d_fast = (d_lo == '0) ? DNW'(1) : d_lo;

	assign adiff   = amax_q - amin_q;
	assign in_band = err_q <= SW'(nb_q);
	assign ediff   = err_q - SW'(nb_q);
	assign span_c  = (nb_q == '0) ? DEN_W'(1) : DEN_W'(nb_q) * aeks_pkg::RAMP_FACTOR;

	assign ramp_alpha = (div_quot > DIV_W'(adiff)) ? amax_q : amin_q + div_quot[AW-1:0];

	// Negative corrections round away from the stored value, positive ones
	// toward it, matching an arithmetic shift of the signed product.
	assign corr_dn = (CRW'(prod_q) + FRAC_MASK) >> FRAC_BITS;
	assign corr_up = prod_q >> FRAC_BITS;
	always_comb begin
		if (neg_q) begin
			result_c = (corr_dn >= CRW'(prev_q)) ? '0 : prev_q - corr_dn[MW-1:0];
		end else begin
			result_c = prev_q + corr_up[MW-1:0];
		end
	end

	// Store port control.
	assign st_rd_en = accept && key_ok && smooth_on;
	always_comb begin
		st_wr_en   = 1'b0;
		st_wr_addr = addr_q;
		st_wr_data = sample_fx;
		if (state_q == S_IDLE) begin
			st_wr_en   = accept && key_ok && !smooth_on;
			st_wr_addr = key_ext[KW-1:0];
			st_wr_data = {raw_in, {FRAC_BITS{1'b0}}};
		end else if (state_q == S_MAG) begin
			st_wr_en = bypass_c;
		end else if (state_q == S_APPLY) begin
			st_wr_en   = 1'b1;
			st_wr_data = result_c;
		end
	end

	always_comb begin
		state_d  = state_q;
		div_go_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (key_ok && smooth_on) ? S_MAG : S_DONE;
				end
			end
			S_MAG: begin
				if (bypass_c) begin
					state_d = S_DONE;
				end else if (stale_q) begin
					state_d  = S_GMIN;
					div_go_d = 1'b1;
				end else begin
					state_d = S_SEL;
				end
			end
			S_GMIN: begin
				if (div_done) begin
					state_d  = S_GMAX;
					div_go_d = 1'b1;
				end
			end
			S_GMAX: begin
				if (div_done) begin
					state_d = S_SEL;
				end
			end
			S_SEL: state_d = in_band ? S_AMUL : S_RMUL;
			S_RMUL: begin
				state_d  = S_RDIV;
				div_go_d = 1'b1;
			end
			S_RDIV: begin
				if (div_done) begin
					state_d = S_AMUL;
				end
			end
			S_AMUL:  state_d = S_APPLY;
			S_APPLY: state_d = S_DONE;
			S_DONE:  state_d = out_free ? S_IDLE : S_HOLD;
			S_HOLD:  state_d = out_free ? S_IDLE : S_HOLD;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			div_go_q <= div_go_d;
			if ((state_q == S_DONE || state_q == S_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE || state_q == S_HOLD) && out_free) begin
			out_sample_q <= OUT_W'(res_sample_q);
			out_path_q   <= res_path_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					addr_q       <= key_ext[KW-1:0];
					sample_q     <= raw_in;
					res_sample_q <= raw_in;
					res_path_q   <= aeks_pkg::PATH_PASS;
				end
			end
			S_MAG: begin
				prev_q       <= st_rd_data;
				neg_q        <= neg_c;
				mag_q        <= mag_c;
				err_q        <= mag_c[MW-1:FRAC_BITS];
				res_sample_q <= sample_q;
				res_path_q   <= aeks_pkg::PATH_BYPASS;
				div_num_q    <= DIV_W'(Q_ONE) + DIV_W'(d_slow >> 1);
				div_den_q    <= DEN_W'(d_slow);
			end
			S_GMIN: begin
				if (div_done) begin
					amin_q    <= div_quot[AW-1:0];
					div_num_q <= DIV_W'(Q_ONE) + DIV_W'(d_fast >> 1);
					div_den_q <= DEN_W'(d_fast);
				end
			end
			S_GMAX: begin
				if (div_done) begin
					amax_q <= div_quot[AW-1:0];
				end
			end
			S_SEL: begin
				alpha_q <= amin_q;
				rprod_q <= RPW'(ediff) * RPW'(adiff);
			end
			S_RMUL: begin
				div_num_q <= DIV_W'(rprod_q) + DIV_W'(span_c >> 1);
				div_den_q <= span_c;
			end
			S_RDIV: begin
				if (div_done) begin
					alpha_q <= ramp_alpha;
				end
			end
			S_AMUL: prod_q <= PW'(alpha_q) * PW'(mag_q);
			S_APPLY: begin
				res_sample_q <= result_c[MW-1:FRAC_BITS];
				res_path_q   <= aeks_pkg::PATH_SMOOTH;
			end
			S_DONE, S_HOLD: begin
			end
			default: begin
			end
		endcase
	end

endmodule
